>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CHECK_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define CHECK_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/spm_pkg.sv
package spm_pkg;

   localparam int DefVertices  = 1024;
   localparam int DefTupleLen  = 8;
   localparam int ScratchSlots = 4;
   localparam int CountW       = 11;
   localparam int SlotW        = 11;
   localparam int PrioW        = 4;
   localparam int PrioEntries  = 16;

   typedef enum logic [2:0] {
      CMD_LOAD  = 3'd0,
      CMD_COPY  = 3'd1,
      CMD_CLEAR = 3'd2,
      CMD_TOP   = 3'd3,
      CMD_SEE   = 3'd4,
      CMD_INC   = 3'd5,
      CMD_CMP   = 3'd6,
      CMD_READ  = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ORD_LESS    = 2'd0,
      ORD_EQUAL   = 2'd1,
      ORD_GREATER = 2'd2
   } order_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FLAGS,
      ST_FLAGS_WAIT,
      ST_RD,
      ST_RD_WAIT,
      ST_ELEM,
      ST_CNT_DEC,
      ST_DONE
   } state_type;

   localparam logic [0:0] RegPlayer  = 1'b0;
   localparam logic [0:0] RegHighest = 1'b1;

endpackage

>>> hw/rtl/small_progress_measure_store_core.sv
// small progress measure store
// commands enter on req_* and are taken when start is high and busy is low;
// each command gives one beat on rsp_* marked by done, held for one cycle.
// the receiver cannot stall; a command is taken again only after its beat.
// player and highest_priority are written through the csr_ apb port; the user
// must write them only while idle, as the block itself does not enforce it.
// commands without tuple work do two flag reads, each read then wait, and the
// beat; clear and copy walk L tuple elements, see and increment walk at most L
// (the walk stops early once the carry dies), and compare reads both operands
// per position and walks from the top position down, at most L positions;
// L = min((highest_priority+2)/2, TUPLE_LEN).
// each tuple element passes through three states on the single-port measure memory
// (read, wait, update). set top and copy add a state for the priority count update.
// busy drops after each beat and stays low until a command is taken, so a
// command is taken only after the last one's beat.
// after reset a clearing pass sweeps the measure memory and the top flags,
// one entry a cycle, over all (VERTICES+4)*TUPLE_LEN entries, holding busy high;
// configuration writes are taken during the pass.
module small_progress_measure_store_core
   import spm_pkg::*;
#(
   parameter int VERTICES  = DefVertices,
   parameter int TUPLE_LEN = DefTupleLen
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   output logic                       done,
   input  logic [2:0]                 req_command,
   input  logic [spm_pkg::SlotW-1:0]  req_target_slot,
   input  logic [spm_pkg::SlotW-1:0]  req_source_slot,
   input  logic [spm_pkg::PrioW-1:0]  req_priority_req,
   input  logic [spm_pkg::CountW-1:0] req_count_value,
   output logic [1:0]                 rsp_order_result,
   output logic                       rsp_target_is_top,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [2:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam int SlotCount = VERTICES + ScratchSlots;
   localparam int SIdxW     = $clog2(SlotCount);
   localparam int EIdxW     = (TUPLE_LEN > 1) ? $clog2(TUPLE_LEN) : 1;
   localparam int LenW      = $clog2(TUPLE_LEN + 1);
   localparam int Depth     = SlotCount * TUPLE_LEN;
   localparam int AddrW     = $clog2(Depth);

   // memories
   logic [CountW-1:0] mem [Depth];
   logic              flag_mem [SlotCount];
   logic [CountW-1:0] cnt_ff [PrioEntries];

   logic [CountW-1:0] mem_rd_ff;
   logic              flag_rd_ff;
   logic [AddrW-1:0]  mem_addr;
   logic              mem_we;
   logic [CountW-1:0] mem_wd;
   logic [SIdxW-1:0]  flag_addr;
   logic              flag_we;
   logic              flag_wd;

   // registers
   state_type         state_ff, state_in;
   logic              player_ff;
   logic [3:0]        highest_ff;
   cmd_type           cmd_ff, cmd_in;
   logic [SIdxW-1:0]  tgt_ff, tgt_in, src_ff, src_in;
   logic              tok_ff, tok_in, sok_ff, sok_in;
   logic [PrioW-1:0]  pr_ff, pr_in;
   logic [CountW-1:0] cv_ff, cv_in;
   logic              ttop_ff, ttop_in, stop_ff, stop_in;
   logic              phase_ff, phase_in; // 0: target, 1: source
   logic [EIdxW-1:0]  idx_ff, idx_in;
   logic [CountW-1:0] a_ff, a_in;
   logic              walk_ff, walk_in;   // see/inc still propagating
   logic [1:0]        ord_ff, ord_in;
   logic              res_top_ff, res_top_in;
   logic              dec_ff, dec_in;
   logic [AddrW-1:0]  clr_ff, clr_in;

   // decoded tuple length
   logic [4:0]        len_raw;
   logic [LenW-1:0]   len;
   logic [EIdxW-1:0]  last_idx;
   logic [4:0]        pos;
   logic [CountW-1:0] pos_cnt;
   logic              cfg_wr;
   logic              dec_go;

   assign len_raw  = (5'(highest_ff) + 5'd2) >> 1;
   assign len      = (32'(len_raw) > TUPLE_LEN) ? LenW'(TUPLE_LEN) : LenW'(len_raw);
   assign last_idx = EIdxW'(len - LenW'(1));
   assign pos      = 5'(player_ff) + {4'(idx_ff), 1'b0};
   assign pos_cnt  = (pos > 5'(highest_ff)) ? '0 : cnt_ff[pos[3:0]];

   // count decrement: vertex slot, matching parity, priority in range
   assign dec_go = dec_ff && (32'(tgt_ff) >= ScratchSlots) &&
                   (pr_ff[0] == player_ff) && (pr_ff <= highest_ff);

   // apb register port
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == RegHighest) csr_prdata[3:0] = highest_ff;
      else                            csr_prdata[0]   = player_ff;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         player_ff  <= 1'b0;
         highest_ff <= '0;
      end else if (cfg_wr && csr_paddr[1:0] == 2'b00) begin
         if (csr_paddr[2] == RegPlayer) player_ff  <= csr_pwdata[0];
         else                           highest_ff <= csr_pwdata[3:0];
      end
   end

   // single-port memories, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wd;
      mem_rd_ff <= mem[mem_addr];
   end
   always_ff @(posedge clock) begin
      if (flag_we) flag_mem[flag_addr] <= flag_wd;
      flag_rd_ff <= flag_mem[flag_addr];
   end

   // priority count table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PrioEntries; i++) cnt_ff[i] <= '0;
      end else if (state_ff == ST_IDLE && start && cmd_in == CMD_LOAD) begin
         cnt_ff[req_priority_req] <= req_count_value;
      end else if (state_ff == ST_CNT_DEC && dec_go && cnt_ff[pr_ff] != '0) begin
         cnt_ff[pr_ff] <= cnt_ff[pr_ff] - CountW'(1);
      end
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;   tgt_ff <= tgt_in;     src_ff <= src_in;
      tok_ff <= tok_in;   sok_ff <= sok_in;     pr_ff <= pr_in;
      cv_ff <= cv_in;     ttop_ff <= ttop_in;   stop_ff <= stop_in;
      phase_ff <= phase_in; idx_ff <= idx_in;   a_ff <= a_in;
      walk_ff <= walk_in; ord_ff <= ord_in;     res_top_ff <= res_top_in;
      dec_ff <= dec_in;
   end

   // element sequencer
   always_comb begin
      logic [CountW-1:0] nv;
      logic              upd, do_wr, stop_walk, last;
      nv = '0; upd = 1'b0; do_wr = 1'b0; stop_walk = 1'b0;
      last = (idx_ff == last_idx);
      state_in = state_ff; clr_in = clr_ff;
      cmd_in = cmd_ff; tgt_in = tgt_ff; src_in = src_ff; tok_in = tok_ff;
      sok_in = sok_ff; pr_in = pr_ff; cv_in = cv_ff; ttop_in = ttop_ff;
      stop_in = stop_ff; phase_in = phase_ff; idx_in = idx_ff; a_in = a_ff;
      walk_in = walk_ff; ord_in = ord_ff; res_top_in = res_top_ff; dec_in = dec_ff;
      mem_addr = AddrW'({tgt_ff, idx_ff}) ; mem_we = 1'b0; mem_wd = '0;
      flag_addr = tgt_ff; flag_we = 1'b0; flag_wd = 1'b0;
      busy = 1'b1; done = 1'b0;
      if (TUPLE_LEN > 1) mem_addr = AddrW'(32'(tgt_ff) * TUPLE_LEN + 32'(idx_ff));
      else               mem_addr = AddrW'(tgt_ff);
      unique case (state_ff)
         ST_CLEAR: begin
            mem_addr = clr_ff; mem_we = 1'b1;
            // flags are cleared while the pass index is below the slot count
            flag_addr = clr_ff[SIdxW-1:0]; flag_we = (32'(clr_ff) < SlotCount);
            if (32'(clr_ff) == Depth - 1) state_in = ST_IDLE;
            else clr_in = clr_ff + AddrW'(1);
         end
         ST_IDLE: begin
            busy = 1'b0;
            cmd_in = cmd_type'(req_command);
            tok_in = 32'(req_target_slot) < SlotCount;
            sok_in = 32'(req_source_slot) < SlotCount;
            tgt_in = SIdxW'(req_target_slot); src_in = SIdxW'(req_source_slot);
            pr_in = req_priority_req; cv_in = req_count_value;
            phase_in = 1'b0; dec_in = 1'b0;
            ord_in = ORD_EQUAL;
            if (start) state_in = ST_FLAGS;
         end
         ST_FLAGS: begin
            // read target flag first, then source flag
            flag_addr = phase_ff ? src_ff : tgt_ff;
            state_in = ST_FLAGS_WAIT;
         end
         ST_FLAGS_WAIT: begin
            if (!phase_ff) begin
               ttop_in = flag_rd_ff && tok_ff;
               phase_in = 1'b1;
               state_in = ST_FLAGS;
            end else begin
               stop_in = flag_rd_ff && sok_ff;
               phase_in = 1'b0;
               walk_in = 1'b1;
               idx_in = (cmd_ff == CMD_CMP) ? last_idx : '0;
               res_top_in = ttop_ff;
               state_in = ST_DONE;
               unique case (cmd_ff)
                  CMD_COPY: if (tok_ff) begin
                     dec_in = !ttop_ff && (flag_rd_ff && sok_ff);
                     res_top_in = flag_rd_ff && sok_ff;
                     flag_addr = tgt_ff; flag_we = 1'b1; flag_wd = flag_rd_ff && sok_ff;
                     state_in = ST_RD;
                  end
                  CMD_CLEAR: if (tok_ff) begin
                     res_top_in = 1'b0;
                     flag_addr = tgt_ff; flag_we = 1'b1; flag_wd = 1'b0;
                     state_in = ST_RD;
                  end
                  CMD_TOP: if (tok_ff) begin
                     dec_in = !ttop_ff; res_top_in = 1'b1;
                     flag_addr = tgt_ff; flag_we = 1'b1; flag_wd = 1'b1;
                     state_in = ST_CNT_DEC;
                  end
                  CMD_SEE, CMD_INC: if (tok_ff && !ttop_ff) state_in = ST_RD;
                  CMD_CMP: begin
                     if (ttop_ff) ord_in = stop_in ? ORD_EQUAL : ORD_GREATER;
                     else if (stop_in) ord_in = ORD_LESS;
                     else state_in = ST_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_RD, ST_RD_WAIT: begin
            // copy, and compare in its source phase, read the source element; others the target
            // the address is held through the wait cycle
            if (cmd_ff == CMD_COPY || (cmd_ff == CMD_CMP && phase_ff)) begin
               if (TUPLE_LEN > 1) mem_addr = AddrW'(32'(src_ff) * TUPLE_LEN + 32'(idx_ff));
               else               mem_addr = AddrW'(src_ff);
            end
            state_in = (state_ff == ST_RD) ? ST_RD_WAIT : ST_ELEM;
         end
         ST_ELEM: begin
            unique case (cmd_ff)
               CMD_COPY: begin
                  upd = 1'b1; nv = sok_ff ? mem_rd_ff : '0;
               end
               CMD_CLEAR: begin
                  upd = 1'b1; nv = '0;
               end
               CMD_SEE: begin
                  if (!walk_ff || pos > 5'(pr_ff)) stop_walk = 1'b1;
                  else if (pos < 5'(pr_ff)) begin upd = 1'b1; nv = '0; end
                  else if (mem_rd_ff >= pos_cnt) begin
                     upd = 1'b1; nv = '0;
                     if (5'(pr_ff) + 5'd2 > 5'(highest_ff)) begin
                        stop_walk = 1'b1; res_top_in = 1'b1;
                        flag_we = 1'b1; flag_wd = 1'b1;
                     end else pr_in = pr_ff + PrioW'(2);
                  end else begin
                     upd = 1'b1; nv = mem_rd_ff + CountW'(1); stop_walk = 1'b1;
                  end
               end
               CMD_INC: begin
                  if (!walk_ff) stop_walk = 1'b1;
                  else if (mem_rd_ff >= pos_cnt) begin
                     upd = 1'b1; nv = '0;
                     if (last) begin
                        res_top_in = 1'b1; flag_we = 1'b1; flag_wd = 1'b1;
                     end
                  end else begin
                     upd = 1'b1; nv = mem_rd_ff + CountW'(1); stop_walk = 1'b1;
                  end
               end
               default: ; // compare
            endcase
            do_wr = upd && tok_ff;
            mem_we = do_wr; mem_wd = nv;
            if (cmd_ff == CMD_CMP) begin
               if (!phase_ff) begin
                  a_in = tok_ff ? mem_rd_ff : '0;
                  phase_in = 1'b1;
                  state_in = ST_RD;
               end else begin
                  phase_in = 1'b0;
                  if (a_ff < (sok_ff ? mem_rd_ff : '0)) begin
                     ord_in = ORD_LESS; state_in = ST_DONE;
                  end else if (a_ff > (sok_ff ? mem_rd_ff : '0)) begin
                     ord_in = ORD_GREATER; state_in = ST_DONE;
                  end else if (idx_ff == '0) state_in = ST_DONE;
                  else begin idx_in = idx_ff - EIdxW'(1); state_in = ST_RD; end
               end
            end else begin
               if (stop_walk) walk_in = 1'b0;
               if (last || stop_walk) state_in = (cmd_ff == CMD_COPY) ? ST_CNT_DEC : ST_DONE;
               else begin idx_in = idx_ff + EIdxW'(1); state_in = ST_RD; end
            end
         end
         ST_CNT_DEC: begin
            // count table updates on this cycle when dec_go holds and the count is nonzero
            state_in = ST_DONE;
         end
         ST_DONE: begin
            done = 1'b1;
            dec_in = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_order_result  = ord_ff;
   assign rsp_target_is_top = res_top_ff;

endmodule

>>> hw/rtl/spm_checker.sv
module spm_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       done,
   input logic [1:0] rsp_order_result
);
`include "assert_macros.svh"

   `CHECK_IMPL(a_done_busy, clock, reset, done, busy)
   `CHECK_NEXT(a_done_free, clock, reset, done, !busy)
   `CHECK_NEXT(a_start_busy, clock, reset, start && !busy, busy && !done)
   `CHECK_IMPL(a_ord_range, clock, reset, done, rsp_order_result != 2'd3)

endmodule

bind small_progress_measure_store_core spm_checker u_spm_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .done(done),
   .rsp_order_result(rsp_order_result)
);
